// ----- hdl/bitmap_page_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// bitmap page allocator assertion macros
// shared property forms used by the allocator modules
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// request and result types, request kinds and controller/datapath links
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_FREE    = 2'd1;
	localparam logic [1:0] REQ_ADD     = 2'd2;
	localparam logic [1:0] REQ_RESERVE = 2'd3;

	localparam logic [32:0] PAGE_MASK33 = 33'h0_0000_0FFF;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] address;
		logic [31:0] length;
		logic [12:0] count;
	} req_t;

	typedef struct packed {
		logic [23:0] page_address;
		logic        status;
	} rsp_t;

	typedef struct packed {
		logic init;
		logic load;
		logic prep;
		logic clip;
		logic fill_wr;
		logic scan_chk;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic is_alloc;
		logic cnt_zero;
		logic empty;
		logic fill_last;
		logic chunk_last;
		logic word_last;
		logic hit;
	} sts_t;

endpackage

// ----- hdl/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpa_ctrl
// sequencer for clearing pass, range fill and first-fit scan
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_defines.svh"

module bpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	input  bpa_pkg::sts_t sts,
	output bpa_pkg::cmd_t cmd
);

	typedef enum logic [8:0] {
		S_INIT     = 9'b000000001,
		S_IDLE     = 9'b000000010,
		S_PREP     = 9'b000000100,
		S_CLIP     = 9'b000001000,
		S_FILL_RD  = 9'b000010000,
		S_FILL_WR  = 9'b000100000,
		S_SCAN_RD  = 9'b001000000,
		S_SCAN_CHK = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			S_INIT: begin
				cmd.init = 1'b1;
				if (sts.init_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nxt = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (!sts.is_alloc) state_nxt = S_CLIP;
				else if (sts.cnt_zero) state_nxt = S_DONE;
				else state_nxt = S_SCAN_RD;
			end
			S_CLIP: begin
				cmd.clip = 1'b1;
				state_nxt = sts.empty ? S_DONE : S_FILL_RD;
			end
			S_FILL_RD: state_nxt = S_FILL_WR;
			S_FILL_WR: begin
				cmd.fill_wr = 1'b1;
				state_nxt = sts.fill_last ? S_DONE : S_FILL_RD;
			end
			S_SCAN_RD: state_nxt = S_SCAN_CHK;
			S_SCAN_CHK: begin
				cmd.scan_chk = 1'b1;
				if (sts.hit) state_nxt = S_FILL_RD;
				else if (sts.chunk_last && sts.word_last) state_nxt = S_DONE;
				else if (sts.chunk_last) state_nxt = S_SCAN_RD;
			end
			S_DONE: state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	`BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`BPA_ASSERT_NEXT(a_done_idle, done, !busy && !done, "no return to idle after result")
	`BPA_ASSERT_NOW(a_done_busy, done, busy, "result strobe while idle")

endmodule

// ----- hdl/bpa_dpath.sv -----
// ----------------------------------------------------------------------------
// bpa_dpath
// bitmap memory, range computation, word fill and run scan
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_defines.svh"

module bpa_dpath #(
	parameter int NUM_PAGES = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bpa_pkg::req_t request,
	input  bpa_pkg::cmd_t cmd,
	output bpa_pkg::sts_t sts,
	output bpa_pkg::rsp_t result
);

	localparam int WORDS = (NUM_PAGES + 31) / 32;
	localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PXW   = WAW + 5;
	localparam int CW    = (PXW + 1 > 13) ? PXW + 1 : 13;
	localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
	localparam logic [21:0]    PC22      = 22'(NUM_PAGES);

	logic [31:0]    mem_q [WORDS];
	logic [31:0]    rdata_q;
	bpa_pkg::req_t  req_q;
	bpa_pkg::rsp_t  res_q;
	logic [20:0]    sp_q, np_q;
	logic [PXW-1:0] s_q, el_q;
	logic [WAW-1:0] w_q;
	logic [1:0]     k_q;
	logic [CW-1:0]  run_q;

	// range prep
	logic [32:0] a33, up33, end33, rem33, rsv33;
	logic [20:0] sp_d, np_d;

	always_comb begin
		a33   = {1'b0, req_q.address};
		up33  = (a33 + bpa_pkg::PAGE_MASK33) & ~bpa_pkg::PAGE_MASK33;
		end33 = a33 + {1'b0, req_q.length};
		rem33 = end33 - up33;
		rsv33 = {1'b0, req_q.length} + 33'(req_q.address[11:0]) + bpa_pkg::PAGE_MASK33;
		sp_d  = {1'b0, req_q.address[31:12]};
		np_d  = '0;
		case (req_q.req_type)
			bpa_pkg::REQ_FREE: np_d = 21'(req_q.count);
			bpa_pkg::REQ_ADD: begin
				sp_d = up33[32:12];
				np_d = (end33 >= up33) ? rem33[32:12] : 21'd0;
			end
			bpa_pkg::REQ_RESERVE: np_d = rsv33[32:12];
			default: np_d = '0;
		endcase
	end

	// clipping
	logic [21:0]    end22, ecl22;
	logic           empty;
	logic [PXW-1:0] s_d, el_d;

	always_comb begin
		end22 = {1'b0, sp_q} + {1'b0, np_q};
		empty = ({1'b0, sp_q} >= PC22) || (np_q == 21'd0);
		ecl22 = (end22 > PC22) ? PC22 : end22;
		el_d  = PXW'(ecl22 - 22'd1);
		s_d   = PXW'(sp_q);
	end

	// fill mask
	logic [31:0] mask, wdata;
	logic        set_m;

	always_comb begin
		for (int b = 0; b < 32; b++) begin
			mask[b] = ((w_q != s_q[PXW-1:5]) || (5'(b) >= s_q[4:0])) &&
				((w_q != el_q[PXW-1:5]) || (5'(b) <= el_q[4:0]));
		end
		set_m = (req_q.req_type == bpa_pkg::REQ_ALLOC) ||
			(req_q.req_type == bpa_pkg::REQ_RESERVE);
		if (cmd.init) wdata = '1;
		else if (set_m) wdata = rdata_q | mask;
		else wdata = rdata_q & ~mask;
	end

	// run scan over one byte of the word
	logic [7:0]     chunk;
	logic [CW-1:0]  run_v, cnt_ext, first_w;
	logic           hit;
	logic [2:0]     hj;
	logic [PXW-1:0] pos, first;
	logic [PXW+11:0] first_b;

	always_comb begin
		chunk   = rdata_q[{k_q, 3'b000} +: 8];
		cnt_ext = CW'(req_q.count);
		run_v   = run_q;
		hit     = 1'b0;
		hj      = '0;
		for (int j = 0; j < 8; j++) begin
			if (!hit) begin
				if (chunk[j]) begin
					run_v = '0;
				end else begin
					run_v = run_v + 1'b1;
					if (run_v == cnt_ext) begin
						hit = 1'b1;
						hj  = 3'(j);
					end
				end
			end
		end
		pos     = {w_q, k_q, hj};
		first_w = CW'(pos) + 1'b1 - cnt_ext;
		first   = first_w[PXW-1:0];
		first_b = {first, 12'h000};
	end

	always_ff @(posedge clk) begin
		if (cmd.init || cmd.fill_wr) mem_q[w_q] <= wdata;
		rdata_q <= mem_q[w_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= request;
		if (cmd.prep) begin
			sp_q <= sp_d;
			np_q <= np_d;
		end
		if (cmd.clip) begin
			s_q  <= s_d;
			el_q <= el_d;
		end else if (cmd.scan_chk && hit) begin
			s_q  <= first;
			el_q <= pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= '0;
			k_q   <= '0;
			run_q <= '0;
			res_q <= '0;
		end else begin
			if (cmd.init || cmd.fill_wr) w_q <= w_q + 1'b1;
			if (cmd.load) begin
				res_q.page_address <= '0;
				res_q.status       <= (request.req_type == bpa_pkg::REQ_ALLOC);
			end
			if (cmd.prep) begin
				w_q   <= '0;
				k_q   <= '0;
				run_q <= '0;
			end
			if (cmd.clip) w_q <= s_d[PXW-1:5];
			if (cmd.scan_chk) begin
				k_q   <= k_q + 1'b1;
				run_q <= run_v;
				if (hit) begin
					w_q                <= first[PXW-1:5];
					res_q.page_address <= 24'(first_b);
					res_q.status       <= 1'b0;
				end else if (k_q == 2'd3) begin
					w_q <= w_q + 1'b1;
				end
			end
		end
	end

	assign sts.init_last  = (w_q == LAST_WORD);
	assign sts.is_alloc   = (req_q.req_type == bpa_pkg::REQ_ALLOC);
	assign sts.cnt_zero   = (req_q.count == 13'd0);
	assign sts.empty      = empty;
	assign sts.fill_last  = (w_q == el_q[PXW-1:5]);
	assign sts.chunk_last = (k_q == 2'd3);
	assign sts.word_last  = (w_q == LAST_WORD);
	assign sts.hit        = hit;

	assign result = res_q;

	`BPA_ASSERT_NOW(a_fail_zero_addr, res_q.status, !(|res_q.page_address), "fail with address")

endmodule

// ----- hdl/bitmap_page_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// first-fit contiguous page allocator over a one-bit-per-page used map
// ----------------------------------------------------------------------------
// after reset busy stays high while the map is written to all-used, one
// 32-bit word per cycle. a request is taken when start is high and busy
// low; its result shows for one cycle with done and cannot be held off,
// and busy drops the cycle after. free, add and reserve go through prep
// and clip, then a read and a write per map word touched, then the result.
// alloc goes through prep, then one read and up to four byte steps of the
// run counter per map word scanned, up to the word that completes the run,
// then a read and a write per word filled, then the result; a failed alloc
// with a nonzero count scans all words. the map has a single port.
module bitmap_page_allocator #(
	parameter int NUM_PAGES = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bpa_pkg::req_t request,
	output logic          done,
	output bpa_pkg::rsp_t result
);

	bpa_pkg::cmd_t cmd;
	bpa_pkg::sts_t sts;

	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	bpa_dpath #(
		.NUM_PAGES (NUM_PAGES)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap page allocator testbench
// drives alloc, free, add and reserve requests through the start/busy
// handshake, keeps its own copy of the page map to predict each result and
// compares every done strobe with the oldest predicted result
// ----------------------------------------------------------------------------
module tb;

	localparam int  PAGES       = 4096;
	localparam int  CYCLE_LIMIT = 4000000;
	localparam int  RANDOM_REQS = 600;

	class page_map_board;
		bit   [PAGES-1:0]    used_map;
		bpa_pkg::rsp_t       pending[$];
		int                  errors;

		function new();
			used_map = '1;
			errors   = 0;
		endfunction

		function void mark(longint unsigned first, longint unsigned n, bit val);
			longint unsigned last;
			if (first >= PAGES)
				return;
			last = first + n;
			if (last > PAGES)
				last = PAGES;
			for (longint unsigned i = first; i < last; i++)
				used_map[i] = val;
		endfunction

		function void note(bpa_pkg::req_t r);
			longint unsigned a, l, c, run, up, down, span;
			bpa_pkg::rsp_t exp_rsp;
			bit found;
			a = r.address;
			l = r.length;
			c = r.count;
			exp_rsp = '0;
			found = 0;
			run = 0;
			case (r.req_type)
				bpa_pkg::REQ_ALLOC: begin
					if (c != 0) begin
						for (longint unsigned i = 0; i < PAGES && !found; i++) begin
							if (used_map[i]) begin
								run = 0;
							end else begin
								run++;
								if (run == c) begin
									mark(i + 1 - c, c, 1'b1);
									exp_rsp.page_address = 24'((i + 1 - c) << 12);
									found = 1;
								end
							end
						end
					end
					if (!found) begin
						exp_rsp.status = 1'b1;
						exp_rsp.page_address = '0;
					end
				end
				bpa_pkg::REQ_FREE: mark(a >> 12, c, 1'b0);
				bpa_pkg::REQ_ADD: begin
					up = ((a + 64'hFFF) >> 12) << 12;
					if (a + l >= up)
						mark(up >> 12, (l - (up - a)) >> 12, 1'b0);
				end
				default: begin
					down = (a >> 12) << 12;
					span = l + (a - down);
					mark(down >> 12, (span + 64'hFFF) >> 12, 1'b1);
				end
			endcase
			pending.push_back(exp_rsp);
		endfunction

		function void check(bpa_pkg::rsp_t got);
			bpa_pkg::rsp_t exp_rsp;
			if (pending.size() == 0) begin
				$error("unexpected result: page_address %h status %0d",
					got.page_address, got.status);
				errors++;
				return;
			end
			exp_rsp = pending.pop_front();
			if (got.page_address !== exp_rsp.page_address) begin
				$error("page_address: expected %h, actual %h",
					exp_rsp.page_address, got.page_address);
				errors++;
			end
			if (got.status !== exp_rsp.status) begin
				$error("status: expected %0d, actual %0d", exp_rsp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	bpa_pkg::req_t  request = '0;
	logic           done;
	bpa_pkg::rsp_t  result;

	page_map_board board = new();
	int    cycles = 0;

	bitmap_page_allocator #(.NUM_PAGES(PAGES)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
		if (arst_n) begin
			if (start && !busy)
				board.note(request);
			if (done)
				board.check(result);
		end
	end

	task automatic send(bpa_pkg::req_t r);
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// idle cycles fall where the block could take a request
	task automatic send_paced(bpa_pkg::req_t r, bit may_idle);
		if (may_idle && $urandom_range(0, 99) < 16) begin
			start <= 1'b0;
			do @(posedge clk); while (busy);
			pause($urandom_range(0, 3));
		end
		send(r);
	endtask

	task automatic drain();
		pause(1);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic bpa_pkg::req_t make_req(logic [1:0] kind, logic [31:0] a,
		logic [31:0] l, logic [12:0] c);
		bpa_pkg::req_t r;
		r.req_type = kind;
		r.address  = a;
		r.length   = l;
		r.count    = c;
		return r;
	endfunction

	function automatic bpa_pkg::req_t random_req();
		bpa_pkg::req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.address = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 24'hFFFFFF);
		r.length  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h60000);
		r.count   = ($urandom_range(0, 19) == 0) ? 13'($urandom_range(0, 8191))
			: 13'($urandom_range(0, 48));
		if (pick < 38) begin
			r.req_type = bpa_pkg::REQ_ALLOC;
		end else if (pick < 60) begin
			r.req_type = bpa_pkg::REQ_FREE;
		end else if (pick < 82) begin
			r.req_type = bpa_pkg::REQ_ADD;
		end else begin
			r.req_type = bpa_pkg::REQ_RESERVE;
			if ($urandom_range(0, 3) != 0)
				r.length = $urandom_range(0, 32'h8000);
		end
		return r;
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all pages used after reset
		send(make_req(bpa_pkg::REQ_ALLOC, 32'h0, 32'h0, 13'd1));
		send(make_req(bpa_pkg::REQ_ADD, 32'h0000_0800, 32'h0000_0400, 13'd0));
		send(make_req(bpa_pkg::REQ_ADD, 32'h0000_0001, 32'h0000_1FFF, 13'd0));
		send(make_req(bpa_pkg::REQ_ALLOC, 32'h0, 32'h0, 13'd1));
		send(make_req(bpa_pkg::REQ_ADD, 32'h0, 32'hFFFF_FFFF, 13'd0));
		send(make_req(bpa_pkg::REQ_ALLOC, 32'h0, 32'h0, 13'd0));
		send(make_req(bpa_pkg::REQ_ALLOC, 32'h0, 32'h0, 13'd4097));
		send(make_req(bpa_pkg::REQ_ALLOC, 32'h0, 32'h0, 13'd8191));
		send(make_req(bpa_pkg::REQ_ALLOC, 32'h0, 32'h0, 13'd4096));
		send(make_req(bpa_pkg::REQ_FREE, 32'h0000_0FFF, 32'hFFFF_FFFF, 13'd0));
		send(make_req(bpa_pkg::REQ_FREE, 32'h0000_0000, 32'h0, 13'd4096));
		send(make_req(bpa_pkg::REQ_RESERVE, 32'h0000_3001, 32'h0, 13'd0));
		send(make_req(bpa_pkg::REQ_RESERVE, 32'h0000_5000, 32'h0, 13'd0));
		send(make_req(bpa_pkg::REQ_ALLOC, 32'h0, 32'h0, 13'd4));
		send(make_req(bpa_pkg::REQ_RESERVE, 32'hFFFF_F000, 32'hFFFF_FFFF, 13'd0));
		send(make_req(bpa_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd0));
		send(make_req(bpa_pkg::REQ_FREE, 32'hFFFF_FFFF, 32'h0, 13'd8191));
		send(make_req(bpa_pkg::REQ_RESERVE, 32'h00FF_F800, 32'h0000_1000, 13'd0));
		send(make_req(bpa_pkg::REQ_ADD, 32'h00FF_E000, 32'h0000_2000, 13'd0));
		send(make_req(bpa_pkg::REQ_ALLOC, 32'h0, 32'h0, 13'd2));
		send(make_req(bpa_pkg::REQ_RESERVE, 32'h0, 32'hFFFF_FFFF, 13'd0));
		send(make_req(bpa_pkg::REQ_ALLOC, 32'h0, 32'h0, 13'd1));
		drain();

		send(make_req(bpa_pkg::REQ_ADD, 32'h0, 32'h0100_0000, 13'd0));
		for (int i = 0; i < RANDOM_REQS; i++) begin
			send_paced(random_req(), !(i >= 200 && i < 350));
			if (i == 400)
				drain();
		end
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
